// File: sv/spectrum_average_peak_capture_unit_macros.svh
// Assertion macros for the spectrum average and peak capture unit.
`ifndef SPECTRUM_AVERAGE_PEAK_CAPTURE_UNIT_MACROS_SVH
`define SPECTRUM_AVERAGE_PEAK_CAPTURE_UNIT_MACROS_SVH

`ifndef SYNTH
`define SPAVG_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("spavg: assertion failed");
`define SPAVG_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("spavg: assertion failed");
`else
`define SPAVG_ASSERT(name, clk, rstn, prop)
`define SPAVG_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// File: sv/spavg_pkg.sv
package spavg_pkg;

  localparam int NUM_BANDS_DEF = 128;
  localparam int MAG_BITS      = 16;
  localparam int COUNT_BITS    = 24;
  localparam int SUM_BITS      = MAG_BITS + COUNT_BITS;
  localparam int IDX_BITS      = 7;

  localparam logic signed [MAG_BITS-1:0] FLOOR_DB = MAG_BITS'(-25600);

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_BAND   = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDWAIT,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    action_e                     action;
    logic signed [MAG_BITS-1:0]  magnitude;
    logic [IDX_BITS-1:0]         band;
  } in_item_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]         band_index;
    logic signed [MAG_BITS-1:0]  average;
    logic signed [MAG_BITS-1:0]  maximum;
    logic [COUNT_BITS-1:0]       frame_count;
    logic                        capturing;
    logic                        accepted;
    logic                        frame_end;
  } out_item_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0]  sum;
    logic signed [MAG_BITS-1:0]  avg;
    logic signed [MAG_BITS-1:0]  peak;
  } row_t;

  localparam int ROW_BITS = $bits(row_t);

  localparam row_t CLEAR_ROW = '{sum: '0, avg: FLOOR_DB, peak: FLOOR_DB};

endpackage

// File: sv/spavg_ram.sv
module spavg_ram #(
  parameter int WIDTH = spavg_pkg::ROW_BITS,
  parameter int DEPTH = spavg_pkg::NUM_BANDS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/spavg_div.sv
module spavg_div (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic signed [spavg_pkg::SUM_BITS-1:0]       dividend_i,
  input  logic        [spavg_pkg::COUNT_BITS-1:0]     divisor_i,
  output logic                                        done_o,
  output logic signed [spavg_pkg::MAG_BITS-1:0]       quotient_o
);

  localparam int MB = spavg_pkg::MAG_BITS;
  localparam int CB = spavg_pkg::COUNT_BITS;
  localparam int SB = spavg_pkg::SUM_BITS;
  localparam int CW = $clog2(MB + 1);

  // The dividend magnitude is below divisor * 2^MB, so the upper bits form a
  // partial remainder that is already smaller than the divisor and only MB
  // quotient bits remain to be found, one per cycle.
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          neg_q, neg_d;
  logic [CB-1:0] rem_q, rem_d;
  logic [MB-1:0] quot_q, quot_d;
  logic [CB-1:0] div_q, div_d;

  logic [SB-1:0] dvd_abs;
  logic [CB:0]   shifted;
  logic [CB:0]   diff;
  logic          ge;

  always_comb begin
    dvd_abs = dividend_i[SB-1] ? unsigned'(-dividend_i) : unsigned'(dividend_i);
    shifted = {rem_q, quot_q[MB-1]};
    diff    = shifted - {1'b0, div_q};
    ge      = shifted >= {1'b0, div_q};

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    div_d  = div_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(MB);
      neg_d  = dividend_i[SB-1];
      rem_d  = dvd_abs[SB-1:MB];
      quot_d = dvd_abs[MB-1:0];
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? diff[CB-1:0] : shifted[CB-1:0];
      quot_d = {quot_q[MB-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    div_q  <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? signed'(MB'(~quot_q + 1'b1)) : signed'(quot_q);

endmodule

// File: sv/spectrum_average_peak_capture_unit.sv
// Spectrum average and peak capture unit. The per-band sum, average and peak
// hold share one row of a single synchronous memory of NUM_BANDS rows, read,
// updated and written back by one item at a time. A band item that is
// accumulated passes from its acceptance to the next acceptance through the
// accepting cycle, a memory read, the serial divider that forms sum / frame
// count, the write-back of the row and the load of the output register. Reads
// and unaccumulated band items skip the divider and write-back; finish and
// out-of-range reads skip the memory read too. Start and reset both run a
// clearing pass over all NUM_BANDS memory rows, during which no item is
// accepted; start then delivers its result. While the output register holds a
// stalled result, the next result waits in ST_DONE and no item is accepted.
`include "spectrum_average_peak_capture_unit_macros.svh"

module spectrum_average_peak_capture_unit #(
  parameter int NUM_BANDS = spavg_pkg::NUM_BANDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  spavg_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output spavg_pkg::out_item_t  out_item_o
);

  localparam int AW = $clog2(NUM_BANDS);
  localparam int MB = spavg_pkg::MAG_BITS;
  localparam int CB = spavg_pkg::COUNT_BITS;
  localparam int SB = spavg_pkg::SUM_BITS;
  localparam int IB = spavg_pkg::IDX_BITS;
  localparam logic [AW-1:0] LAST_BAND = AW'(NUM_BANDS - 1);

  spavg_pkg::state_e state_q, state_d;

  logic [AW-1:0]        clr_idx_q, clr_idx_d;
  logic                 clr_reply_q, clr_reply_d;
  logic                 capture_q, capture_d;
  logic [CB-1:0]        frames_q, frames_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic                 dropped_q, dropped_d;
  logic [AW-1:0]        p_q, p_d;
  logic signed [MB-1:0] mag_q, mag_d;
  logic                 upd_q, upd_d;
  logic signed [SB-1:0] sum_q, sum_d;
  logic [IB-1:0]        res_idx_q, res_idx_d;
  logic signed [MB-1:0] res_avg_q, res_avg_d;
  logic signed [MB-1:0] res_max_q, res_max_d;
  logic                 res_acc_q, res_acc_d;
  logic                 res_fend_q, res_fend_d;

  logic                 out_valid_q;
  spavg_pkg::out_item_t out_q, out_d;
  logic                 load_out;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  spavg_pkg::row_t      ram_wdata;
  logic [AW-1:0]        ram_raddr;
  spavg_pkg::row_t      ram_rdata;

  logic                 div_start;
  logic                 div_done;
  logic signed [MB-1:0] div_quot;

  logic signed [SB-1:0] sum_new;
  logic                 drop_now;
  logic                 band_last;
  logic                 rd_in_range;

  logic                 start_fire;
  logic                 clear_begun;
  logic                 acc_shown;
  logic                 acc_legal;

  spavg_ram #(
    .WIDTH (spavg_pkg::ROW_BITS),
    .DEPTH (NUM_BANDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  spavg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new),
    .divisor_i  (frames_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    sum_new     = ram_rdata.sum + SB'(mag_q);
    drop_now    = (pos_q == '0) ? (frames_q == '1) : dropped_q;
    band_last   = pos_q == LAST_BAND;
    rd_in_range = 32'(in_item_i.band) < 32'(NUM_BANDS);

    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    clr_reply_d = clr_reply_q;
    capture_d   = capture_q;
    frames_d    = frames_q;
    pos_d       = pos_q;
    dropped_d   = dropped_q;
    p_d         = p_q;
    mag_d       = mag_q;
    upd_d       = upd_q;
    sum_d       = sum_q;
    res_idx_d   = res_idx_q;
    res_avg_d   = res_avg_q;
    res_max_d   = res_max_q;
    res_acc_d   = res_acc_q;
    res_fend_d  = res_fend_q;

    ram_we      = 1'b0;
    ram_waddr   = p_q;
    ram_wdata   = '{sum: sum_q, avg: div_quot, peak: res_max_q};
    ram_raddr   = (in_item_i.action == spavg_pkg::ACT_READ) ? AW'(in_item_i.band) : pos_q;
    div_start   = 1'b0;
    load_out    = 1'b0;

    case (state_q)
      spavg_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
        ram_wdata = spavg_pkg::CLEAR_ROW;
        if (clr_idx_q == LAST_BAND) begin
          clr_idx_d   = '0;
          clr_reply_d = 1'b0;
          state_d     = clr_reply_q ? spavg_pkg::ST_DONE : spavg_pkg::ST_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + 1'b1;
        end
      end
      spavg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          res_acc_d  = 1'b0;
          res_fend_d = 1'b0;
          upd_d      = 1'b0;
          case (in_item_i.action)
            spavg_pkg::ACT_START: begin
              capture_d   = 1'b1;
              frames_d    = '0;
              pos_d       = '0;
              dropped_d   = 1'b0;
              clr_reply_d = 1'b1;
              res_idx_d   = '0;
              res_avg_d   = spavg_pkg::FLOOR_DB;
              res_max_d   = spavg_pkg::FLOOR_DB;
              state_d     = spavg_pkg::ST_CLEAR;
            end
            spavg_pkg::ACT_FINISH: begin
              capture_d = 1'b0;
              res_idx_d = '0;
              res_avg_d = '0;
              res_max_d = '0;
              state_d   = spavg_pkg::ST_DONE;
            end
            spavg_pkg::ACT_READ: begin
              res_idx_d = in_item_i.band;
              if (rd_in_range) begin
                state_d = spavg_pkg::ST_RDWAIT;
              end else begin
                res_avg_d = spavg_pkg::FLOOR_DB;
                res_max_d = spavg_pkg::FLOOR_DB;
                state_d   = spavg_pkg::ST_DONE;
              end
            end
            spavg_pkg::ACT_BAND: begin
              res_idx_d = IB'(pos_q);
              p_d       = pos_q;
              mag_d     = in_item_i.magnitude;
              if (capture_q) begin
                if (pos_q == '0) begin
                  dropped_d = frames_q == '1;
                  if (frames_q != '1) begin
                    frames_d = frames_q + 1'b1;
                  end
                end
                upd_d      = !drop_now;
                res_acc_d  = !drop_now;
                res_fend_d = band_last;
                pos_d      = band_last ? '0 : pos_q + 1'b1;
              end
              state_d = spavg_pkg::ST_RDWAIT;
            end
            default: begin
              state_d = spavg_pkg::ST_IDLE;
            end
          endcase
        end
      end
      spavg_pkg::ST_RDWAIT: begin
        if (upd_q) begin
          sum_d     = sum_new;
          res_max_d = (mag_q > ram_rdata.peak) ? mag_q : ram_rdata.peak;
          div_start = 1'b1;
          state_d   = spavg_pkg::ST_DIV;
        end else begin
          res_avg_d = ram_rdata.avg;
          res_max_d = ram_rdata.peak;
          state_d   = spavg_pkg::ST_DONE;
        end
      end
      spavg_pkg::ST_DIV: begin
        if (div_done) begin
          ram_we    = 1'b1;
          res_avg_d = div_quot;
          state_d   = spavg_pkg::ST_DONE;
        end
      end
      spavg_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = spavg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spavg_pkg::ST_IDLE;
      end
    endcase

    out_d = '{band_index:  res_idx_q,
              average:     res_avg_q,
              maximum:     res_max_q,
              frame_count: frames_q,
              capturing:   capture_q,
              accepted:    res_acc_q,
              frame_end:   res_fend_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spavg_pkg::ST_CLEAR;
      clr_idx_q   <= '0;
      clr_reply_q <= 1'b0;
      capture_q   <= 1'b0;
      frames_q    <= '0;
      pos_q       <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      clr_reply_q <= clr_reply_d;
      capture_q   <= capture_d;
      frames_q    <= frames_d;
      pos_q       <= pos_d;
      dropped_q   <= dropped_d;
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= load_out;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    mag_q      <= mag_d;
    upd_q      <= upd_d;
    sum_q      <= sum_d;
    res_idx_q  <= res_idx_d;
    res_avg_q  <= res_avg_d;
    res_max_q  <= res_max_d;
    res_acc_q  <= res_acc_d;
    res_fend_q <= res_fend_d;
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = state_q != spavg_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign start_fire  = in_valid_i && !in_stall_o && in_item_i.action == spavg_pkg::ACT_START;
  assign clear_begun = capture_q && frames_q == '0 && state_q == spavg_pkg::ST_CLEAR;
  assign acc_shown   = out_valid_o && out_item_o.accepted;
  assign acc_legal   = out_item_o.capturing && out_item_o.frame_count != '0;

  `SPAVG_ASSERT(a_div_done_in_div, clk_i, rst_ni, div_done |-> state_q == spavg_pkg::ST_DIV)
  `SPAVG_ASSERT(a_pos_in_range, clk_i, rst_ni, 32'(pos_q) < 32'(NUM_BANDS))
  `SPAVG_ASSERT(a_start_clears, clk_i, rst_ni, start_fire |=> clear_begun)
  `SPAVG_ASSERT(a_accepted_capturing, clk_i, rst_ni, acc_shown |-> acc_legal)

endmodule
